// ===== src/curlcurl_qpoint_geometric_factor_assert.svh =====
// Assertion helpers for the quadrature-point geometric factor block.
// Both macros expect clk_i and rst_ni to be visible where they are used.
`ifndef CURLCURL_QPOINT_GEOMETRIC_FACTOR_ASSERT_SVH
`define CURLCURL_QPOINT_GEOMETRIC_FACTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CQGF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cqgf: invariant violated");
`define CQGF_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cqgf: implication violated");
`else
`define CQGF_ASSERT(lbl, prop)
`define CQGF_ASSERT_IMPLIES(lbl, ante, cons)
`endif
`endif

// ===== src/cqgf_pkg.sv =====
`default_nettype none
package cqgf_pkg;

  localparam int unsigned JW   = 32;      // Jacobian entry and coefficient width
  localparam int unsigned WW   = 16;      // quadrature weight width
  localparam int unsigned WSH  = 8;       // weight pre-scale so the result lands in Q24.24
  localparam int unsigned OW   = 48;      // result entry width
  localparam int unsigned SW   = 2;       // status width
  localparam int unsigned NENT = 6;       // upper-triangle entries
  localparam int unsigned MW   = 65;      // cofactor minors and Gram entries, signed
  localparam int unsigned KW   = 56;      // w * k * 2^8, signed
  localparam int unsigned DW   = 97;      // determinant, signed
  localparam int unsigned NW   = 120;     // numerator w * k * M * 2^8, signed
  localparam int unsigned DMW  = DW - 1;  // determinant magnitude
  localparam int unsigned NMW  = NW - 1;  // numerator magnitude
  localparam int unsigned QW   = OW;      // quotient bits produced by the divider

  localparam logic [SW-1:0] ST_OK       = 2'd0;
  localparam logic [SW-1:0] ST_DET_ZERO = 2'd1;
  localparam logic [SW-1:0] ST_SAT      = 2'd2;

  typedef struct packed {
    logic signed [JW-1:0] jac_11;
    logic signed [JW-1:0] jac_21;
    logic signed [JW-1:0] jac_31;
    logic signed [JW-1:0] jac_12;
    logic signed [JW-1:0] jac_22;
    logic signed [JW-1:0] jac_32;
    logic signed [JW-1:0] jac_13;
    logic signed [JW-1:0] jac_23;
    logic signed [JW-1:0] jac_33;
    logic        [WW-1:0] weight;
    logic signed [JW-1:0] coefficient;
  } in_item_t;

  // Exact determinant and the six exact numerators, handed to the divider.
  typedef struct packed {
    logic signed [DW-1:0]         det;
    logic [NENT-1:0][NW-1:0]      num;
  } frac_t;

  typedef struct packed {
    logic signed [OW-1:0] out_d11;
    logic signed [OW-1:0] out_d12;
    logic signed [OW-1:0] out_d13;
    logic signed [OW-1:0] out_d22;
    logic signed [OW-1:0] out_d23;
    logic signed [OW-1:0] out_d33;
    logic        [SW-1:0] status;
  } res_t;

endpackage
`default_nettype wire

// ===== src/cqgf_front.sv =====
`default_nettype none
// Five-stage multiply front end: exact determinant and numerators.
module cqgf_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire cqgf_pkg::in_item_t data_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output cqgf_pkg::frac_t         data_o
);

  localparam int unsigned NST  = 5;
  localparam int unsigned NE   = cqgf_pkg::NENT;
  localparam int unsigned JW   = cqgf_pkg::JW;
  localparam int unsigned MW   = cqgf_pkg::MW;
  localparam int unsigned KW   = cqgf_pkg::KW;
  localparam int unsigned DW   = cqgf_pkg::DW;
  localparam int unsigned NW   = cqgf_pkg::NW;
  localparam int unsigned WW   = cqgf_pkg::WW;
  localparam int unsigned WSH  = cqgf_pkg::WSH;
  localparam int unsigned WLO  = 28;   // low split of w*k
  localparam int unsigned MLO  = 33;   // low split of a Gram entry
  localparam logic [1:0] PA [NE] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PB [NE] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  logic [NST-1:0] v_q;
  logic [NST-1:0] vin;
  logic [NST-1:0] ld;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = ready_i;
    for (int s = NST - 1; s >= 0; s--) begin
      rdy[s] = ~v_q[s] | rdy[s+1];
    end
  end

  assign vin = {v_q[NST-2:0], valid_i};
  assign ld  = vin & rdy[NST-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= ld | (v_q & ~rdy[NST-1:0]);
    end
  end

  // Stage 1: all 32x32 products.
  logic signed [JW-1:0]    col [3][3];
  logic signed [WW+WSH:0]  wsc;
  logic signed [KW:0]      wk_full;
  logic signed [2*JW-1:0]  mp_q [6];
  logic signed [2*JW-1:0]  gp_q [NE][3];
  logic signed [KW-1:0]    wk1_q;
  logic signed [JW-1:0]    j1_q [3];

  always_comb begin
    col[0][0] = data_i.jac_11;
    col[0][1] = data_i.jac_21;
    col[0][2] = data_i.jac_31;
    col[1][0] = data_i.jac_12;
    col[1][1] = data_i.jac_22;
    col[1][2] = data_i.jac_32;
    col[2][0] = data_i.jac_13;
    col[2][1] = data_i.jac_23;
    col[2][2] = data_i.jac_33;
  end

  assign wsc     = $signed({1'b0, data_i.weight, {WSH{1'b0}}});
  assign wk_full = wsc * data_i.coefficient;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      mp_q[0] <= data_i.jac_22 * data_i.jac_33;
      mp_q[1] <= data_i.jac_32 * data_i.jac_23;
      mp_q[2] <= data_i.jac_12 * data_i.jac_33;
      mp_q[3] <= data_i.jac_32 * data_i.jac_13;
      mp_q[4] <= data_i.jac_12 * data_i.jac_23;
      mp_q[5] <= data_i.jac_22 * data_i.jac_13;
      for (int e = 0; e < NE; e++) begin
        for (int r = 0; r < 3; r++) begin
          gp_q[e][r] <= col[PA[e]][r] * col[PB[e]][r];
        end
      end
      wk1_q <= wk_full[KW-1:0];
      for (int r = 0; r < 3; r++) begin
        j1_q[r] <= col[0][r];
      end
    end
  end

  // Stage 2: cofactor minors and Gram sums.
  logic signed [MW-1:0] c_q [3];
  logic signed [MW-1:0] m_q [NE];
  logic signed [KW-1:0] wk2_q;
  logic signed [JW-1:0] j2_q [3];

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      for (int i = 0; i < 3; i++) begin
        c_q[i]  <= MW'(mp_q[2*i]) - MW'(mp_q[2*i+1]);
        j2_q[i] <= j1_q[i];
      end
      for (int e = 0; e < NE; e++) begin
        m_q[e] <= MW'(gp_q[e][0]) + MW'(gp_q[e][1]) + MW'(gp_q[e][2]);
      end
      wk2_q <= wk1_q;
    end
  end

  // Stage 3: split products, no multiplier wider than about 32x32.
  logic signed [MW-1:0]      tl_q [3];
  logic signed [MW-1:0]      th_q [3];
  logic signed [63:0]        ll_q [NE];
  logic signed [61:0]        lh_q [NE];
  logic signed [61:0]        hl_q [NE];
  logic signed [59:0]        hh_q [NE];
  logic signed [WLO:0]       wl;
  logic signed [KW-WLO-1:0]  wh;

  assign wl = $signed({1'b0, wk2_q[WLO-1:0]});
  assign wh = $signed(wk2_q[KW-1:WLO]);

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        tl_q[i] <= $signed({1'b0, c_q[i][JW-1:0]}) * j2_q[i];
        th_q[i] <= $signed(c_q[i][MW-1:JW]) * j2_q[i];
      end
      for (int e = 0; e < NE; e++) begin
        ll_q[e] <= wl * $signed({1'b0, m_q[e][MLO-1:0]});
        lh_q[e] <= wl * $signed(m_q[e][MW-1:MLO]);
        hl_q[e] <= wh * $signed({1'b0, m_q[e][MLO-1:0]});
        hh_q[e] <= wh * $signed(m_q[e][MW-1:MLO]);
      end
    end
  end

  // Stage 4: recombine partial products.
  logic signed [DW-1:0] t_q  [3];
  logic signed [NW-1:0] x1_q [NE];
  logic signed [NW-1:0] x2_q [NE];

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      for (int i = 0; i < 3; i++) begin
        t_q[i] <= (DW'(th_q[i]) <<< JW) + DW'(tl_q[i]);
      end
      for (int e = 0; e < NE; e++) begin
        x1_q[e] <= (NW'(hh_q[e]) <<< (WLO + MLO)) + NW'(ll_q[e]);
        x2_q[e] <= (NW'(lh_q[e]) <<< MLO) + (NW'(hl_q[e]) <<< WLO);
      end
    end
  end

  // Stage 5: cofactor expansion along the first column and final numerators.
  cqgf_pkg::frac_t out_q;

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      out_q.det <= t_q[0] - t_q[1] + t_q[2];
      for (int e = 0; e < NE; e++) begin
        out_q.num[e] <= x1_q[e] + x2_q[e];
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NST-1];
  assign data_o  = out_q;

endmodule
`default_nettype wire

// ===== src/cqgf_div.sv =====
`default_nettype none
// Six-lane pipelined restoring divider with rounding and saturation.
module cqgf_div (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire cqgf_pkg::frac_t data_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output cqgf_pkg::res_t       data_o
);

  localparam int unsigned NE     = cqgf_pkg::NENT;
  localparam int unsigned QW     = cqgf_pkg::QW;
  localparam int unsigned DW     = cqgf_pkg::DW;
  localparam int unsigned DMW    = cqgf_pkg::DMW;
  localparam int unsigned NW     = cqgf_pkg::NW;
  localparam int unsigned NMW    = cqgf_pkg::NMW;
  localparam int unsigned NST    = QW + 4;
  localparam int unsigned S_ABS  = 0;
  localparam int unsigned S_INIT = 1;
  localparam int unsigned S_RND  = QW + 2;
  localparam int unsigned S_OUT  = QW + 3;
  localparam logic [QW:0] LIM_POS = {2'b00, {(QW-1){1'b1}}};
  localparam logic [QW:0] LIM_NEG = {2'b01, {(QW-1){1'b0}}};

  logic [NST-1:0] v_q;
  logic [NST-1:0] vin;
  logic [NST-1:0] ld;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = ready_i;
    for (int s = NST - 1; s >= 0; s--) begin
      rdy[s] = ~v_q[s] | rdy[s+1];
    end
  end

  assign vin = {v_q[NST-2:0], valid_i};
  assign ld  = vin & rdy[NST-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= ld | (v_q & ~rdy[NST-1:0]);
    end
  end

  // Magnitudes and result signs.
  logic signed [DW-1:0] det_in;
  logic signed [NW-1:0] num_in [NE];
  logic [DMW-1:0]       dmag_d;
  logic [NMW-1:0]       nmag_d [NE];
  logic [NE-1:0]        neg_d;
  logic                 dz_d;
  logic [DMW-1:0]       dmag0_q;
  logic [NMW-1:0]       nmag0_q [NE];
  logic [NE-1:0]        neg0_q;
  logic                 dz0_q;

  always_comb begin
    det_in = data_i.det;
    dmag_d = det_in[DW-1] ? DMW'(-det_in) : DMW'(det_in);
    dz_d   = (det_in == '0);
    for (int e = 0; e < NE; e++) begin
      num_in[e] = $signed(data_i.num[e]);
      nmag_d[e] = num_in[e][NW-1] ? NMW'(-num_in[e]) : NMW'(num_in[e]);
      neg_d[e]  = num_in[e][NW-1] ^ det_in[DW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[S_ABS]) begin
      dmag0_q <= dmag_d;
      nmag0_q <= nmag_d;
      neg0_q  <= neg_d;
      dz0_q   <= dz_d;
    end
  end

  // Division stages. Index 0 holds the initial remainder, index k+1 the
  // state after quotient bit k. The low numerator bits shift out of quo_q
  // while quotient bits shift in.
  logic [DMW-1:0] rem_q [QW+1][NE];
  logic [QW-1:0]  quo_q [QW+1][NE];
  logic [DMW-1:0] dv_q  [QW+1];
  logic [NE-1:0]  neg_q [QW+1];
  logic [NE-1:0]  big_q [QW+1];
  logic [QW:0]    dz_q;

  // If the top numerator bits already reach the divisor, the quotient is
  // at least 2^48 and the entry saturates whatever the low bits are.
  always_ff @(posedge clk_i) begin
    if (ld[S_INIT]) begin
      for (int e = 0; e < NE; e++) begin
        rem_q[0][e] <= DMW'(nmag0_q[e][NMW-1:QW]);
        quo_q[0][e] <= nmag0_q[e][QW-1:0];
        big_q[0][e] <= (DMW'(nmag0_q[e][NMW-1:QW]) >= dmag0_q);
      end
      dv_q[0]  <= dmag0_q;
      neg_q[0] <= neg0_q;
      dz_q[0]  <= dz0_q;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DMW:0]  trial [NE];
    logic [DMW:0]  diff  [NE];
    logic [NE-1:0] qbit;

    always_comb begin
      for (int e = 0; e < NE; e++) begin
        trial[e] = {rem_q[k][e], quo_q[k][e][QW-1]};
        diff[e]  = trial[e] - {1'b0, dv_q[k]};
        qbit[e]  = (trial[e] >= {1'b0, dv_q[k]});
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[S_INIT+1+k]) begin
        for (int e = 0; e < NE; e++) begin
          rem_q[k+1][e] <= qbit[e] ? diff[e][DMW-1:0] : trial[e][DMW-1:0];
          quo_q[k+1][e] <= {quo_q[k][e][QW-2:0], qbit[e]};
        end
        dv_q[k+1]  <= dv_q[k];
        neg_q[k+1] <= neg_q[k];
        big_q[k+1] <= big_q[k];
        dz_q[k+1]  <= dz_q[k];
      end
    end
  end

  // Round to nearest, ties away from zero.
  logic [QW:0]   qr_q [NE];
  logic [NE-1:0] negr_q;
  logic [NE-1:0] bigr_q;
  logic          dzr_q;

  always_ff @(posedge clk_i) begin
    if (ld[S_RND]) begin
      for (int e = 0; e < NE; e++) begin
        qr_q[e] <= {1'b0, quo_q[QW][e]}
                 + (QW+1)'({rem_q[QW][e], 1'b0} >= {1'b0, dv_q[QW]});
      end
      negr_q <= neg_q[QW];
      bigr_q <= big_q[QW];
      dzr_q  <= dz_q[QW];
    end
  end

  // Clamp, apply the sign and build the result.
  logic [QW:0]    lim  [NE];
  logic [QW:0]    mag  [NE];
  logic [QW:0]    sval [NE];
  logic [QW-1:0]  val  [NE];
  logic [NE-1:0]  sat;
  cqgf_pkg::res_t res_d;
  cqgf_pkg::res_t res_q;

  always_comb begin
    for (int e = 0; e < NE; e++) begin
      lim[e]  = negr_q[e] ? LIM_NEG : LIM_POS;
      sat[e]  = bigr_q[e] | (qr_q[e] > lim[e]);
      mag[e]  = sat[e] ? lim[e] : qr_q[e];
      sval[e] = negr_q[e] ? -mag[e] : mag[e];
      val[e]  = sval[e][QW-1:0];
    end
    if (dzr_q) begin
      res_d         = '0;
      res_d.status  = cqgf_pkg::ST_DET_ZERO;
    end else begin
      res_d.out_d11 = val[0];
      res_d.out_d12 = val[1];
      res_d.out_d13 = val[2];
      res_d.out_d22 = val[3];
      res_d.out_d23 = val[4];
      res_d.out_d33 = val[5];
      res_d.status  = (|sat) ? cqgf_pkg::ST_SAT : cqgf_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[S_OUT]) begin
      res_q <= res_d;
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NST-1];
  assign data_o  = res_q;

endmodule
`default_nettype wire

// ===== src/curlcurl_qpoint_geometric_factor.sv =====
// Channel   Handshake                  Payload                         Direction
// input     in_valid_i / in_ready_o    in_data_i  (cqgf_pkg::in_item_t) into block
// output    out_valid_o / out_ready_i  out_data_o (cqgf_pkg::res_t)     out of block
//
// One transfer is taken per cycle unless a stalled output has backed up to the input.
// The divider runs 48 one-bit restoring steps per entry in six lanes, then rounds.
// The front end adds five stages (products, sums, split products, recombine, det).
// Reset clears only the valid bits of every stage; data registers are not reset.
// A full stage holds while the stage after it cannot move on, so empty stages keep
// filling behind a stalled output and nothing is dropped or repeated.
`default_nettype none
`include "curlcurl_qpoint_geometric_factor_assert.svh"
module curlcurl_qpoint_geometric_factor (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire cqgf_pkg::in_item_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output cqgf_pkg::res_t          out_data_o
);

  // Between the two halves travels the exact determinant and the six exact
  // numerators w * k * Mij * 2^8, wide enough that nothing is rounded there.
  logic            mid_valid;
  logic            mid_ready;
  cqgf_pkg::frac_t mid_data;

  // The front end forms all products with multipliers of about 32x32 bits and
  // expands the determinant along the first column.
  cqgf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .data_o  (mid_data)
  );

  // The divider works on magnitudes. The top numerator bits are checked
  // against the divisor first, so only 48 quotient bits are ever needed.
  // A zero determinant forces zero outputs and its own status code.
  cqgf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .data_i  (mid_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  // The input side can only be blocked by a result that is waiting at the output.
  `CQGF_ASSERT(a_stall_from_output, in_ready_o || (out_valid_o && !out_ready_i))

  // A singular Jacobian must deliver all six entries as zero.
  `CQGF_ASSERT_IMPLIES(a_det_zero_clears,
    out_valid_o && out_data_o.status == cqgf_pkg::ST_DET_ZERO,
    out_data_o.out_d11 == '0 && out_data_o.out_d12 == '0 && out_data_o.out_d13 == '0 &&
    out_data_o.out_d22 == '0 && out_data_o.out_d23 == '0 && out_data_o.out_d33 == '0)

endmodule
`default_nettype wire

// ===== verif/curlcurl_qpoint_geometric_factor_tb.sv =====
`default_nettype none
// Testbench for the quadrature-point geometric factor block.
// Stimulus items are queued by an initial block and presented by a clocked driver.
// A clocked monitor compares every output transfer against the oldest predicted result.
module curlcurl_qpoint_geometric_factor_tb;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  cqgf_pkg::in_item_t in_data;
  logic               out_valid;
  logic               out_ready;
  cqgf_pkg::res_t     out_data;

  curlcurl_qpoint_geometric_factor dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Items waiting to be driven, and results predicted for items already transferred.
  cqgf_pkg::in_item_t pending_items[$];
  cqgf_pkg::res_t     expected_factors[$];

  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_cycles;
  bit          hold_off_req;
  bit          hold_off_taken;

  // Rounded, saturated quotient of an exact numerator and a nonzero determinant.
  // The operand magnitudes fit easily in 256 bits, so plain wide arithmetic is exact.
  function automatic logic [cqgf_pkg::OW-1:0] round_quotient(
                                                   input logic signed [255:0] num,
                                                   input logic signed [255:0] det,
                                                   inout bit clamped);
    logic [255:0] num_mag;
    logic [255:0] det_mag;
    logic [255:0] quo;
    logic [255:0] rem;
    logic [255:0] lim;
    bit           neg;
    neg     = (num < 0) != (det < 0) && num != 0;
    num_mag = (num < 0) ? -num : num;
    det_mag = (det < 0) ? -det : det;
    quo     = num_mag / det_mag;
    rem     = num_mag % det_mag;
    // Ties round away from zero: bump when twice the remainder reaches the divisor.
    if ((rem << 1) >= det_mag) quo = quo + 1;
    lim = neg ? (256'd1 << 47) : ((256'd1 << 47) - 1);
    if (quo > lim) begin
      quo     = lim;
      clamped = 1'b1;
    end
    if (neg) quo = -quo;
    return quo[cqgf_pkg::OW-1:0];
  endfunction

  // Computes w * k * (J^T J) / det(J), scaled by 2^8, for one quadrature point from exact integer sums.
  function automatic cqgf_pkg::res_t geometric_factor(input cqgf_pkg::in_item_t it);
    logic signed [255:0]       j11, j21, j31, j12, j22, j32, j13, j23, j33;
    logic signed [255:0]       det;
    logic signed [255:0]       wk;
    logic signed [255:0]       gram[cqgf_pkg::NENT];
    logic [cqgf_pkg::OW-1:0]   ent[cqgf_pkg::NENT];
    bit                        clamped;
    cqgf_pkg::res_t            r;
    j11 = it.jac_11; j21 = it.jac_21; j31 = it.jac_31;
    j12 = it.jac_12; j22 = it.jac_22; j32 = it.jac_32;
    j13 = it.jac_13; j23 = it.jac_23; j33 = it.jac_33;
    clamped = 1'b0;
    det = j11 * (j22 * j33 - j32 * j23) - j21 * (j12 * j33 - j32 * j13)
        + j31 * (j12 * j23 - j22 * j13);
    if (det == 0) begin
      r        = '0;
      r.status = cqgf_pkg::ST_DET_ZERO;
      return r;
    end
    gram[0] = j11 * j11 + j21 * j21 + j31 * j31;
    gram[1] = j11 * j12 + j21 * j22 + j31 * j32;
    gram[2] = j11 * j13 + j21 * j23 + j31 * j33;
    gram[3] = j12 * j12 + j22 * j22 + j32 * j32;
    gram[4] = j12 * j13 + j22 * j23 + j32 * j33;
    gram[5] = j13 * j13 + j23 * j23 + j33 * j33;
    wk = $signed({240'd0, it.weight}) * 256 * $signed(it.coefficient);
    for (int i = 0; i < cqgf_pkg::NENT; i++) begin
      ent[i] = round_quotient(wk * gram[i], det, clamped);
    end
    r.out_d11 = ent[0];
    r.out_d12 = ent[1];
    r.out_d13 = ent[2];
    r.out_d22 = ent[3];
    r.out_d23 = ent[4];
    r.out_d33 = ent[5];
    r.status  = clamped ? cqgf_pkg::ST_SAT : cqgf_pkg::ST_OK;
    return r;
  endfunction

  // Random Jacobian entry: mostly moderate Q16.16 values, sometimes any 32-bit word
  // or an extreme, so every bit toggles and saturation shows up now and then.
  function automatic logic [31:0] rand_entry();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
    if (pick < 80) return $urandom;
    if (pick < 85) return 32'h8000_0000;
    if (pick < 90) return 32'h7fff_ffff;
    return 32'($signed($urandom_range(32)) - 16);
  endfunction

  function automatic cqgf_pkg::in_item_t rand_item();
    cqgf_pkg::in_item_t it;
    it.jac_11      = rand_entry();
    it.jac_21      = rand_entry();
    it.jac_31      = rand_entry();
    it.jac_12      = rand_entry();
    it.jac_22      = rand_entry();
    it.jac_32      = rand_entry();
    it.jac_13      = rand_entry();
    it.jac_23      = rand_entry();
    it.jac_33      = rand_entry();
    it.weight      = 16'($urandom);
    it.coefficient = ($urandom_range(3) == 0) ? $urandom : rand_entry();
    // A copied column makes the determinant vanish.
    if ($urandom_range(19) == 0) begin
      it.jac_13 = it.jac_11;
      it.jac_23 = it.jac_21;
      it.jac_33 = it.jac_31;
    end
    return it;
  endfunction

  function automatic cqgf_pkg::in_item_t diag_item(input logic [31:0] d1,
                                                   input logic [31:0] d2,
                                                   input logic [31:0] d3,
                                                   input logic [15:0] w,
                                                   input logic [31:0] k);
    cqgf_pkg::in_item_t it;
    it             = '0;
    it.jac_11      = d1;
    it.jac_22      = d2;
    it.jac_33      = d3;
    it.weight      = w;
    it.coefficient = k;
    return it;
  endfunction

  // Driver: valid stays up with a steady payload until the transfer completes.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) expected_factors.push_back(geometric_factor(in_data));
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here once it has been requested.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_off_cycles <= 0;
      hold_off_taken  <= 1'b0;
    end else if (hold_off_req && !hold_off_taken) begin
      hold_off_cycles <= 200;
      hold_off_taken  <= 1'b1;
    end else if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
    end
  end

  // Receiver ready: random stalls, or held low during the long hold-off.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_cycles != 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: each output transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_factors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transfer: %p", out_data);
      end else begin
        cqgf_pkg::res_t want;
        want = expected_factors.pop_front();
        if (out_data !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch\n  expected %p\n  actual   %p", want, out_data);
        end
      end
    end
  end

  task automatic run_phase(input int unsigned n, input int unsigned idle,
                           input int unsigned stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) pending_items.push_back(rand_item());
    while (pending_items.size() != 0) @(posedge clk);
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b0;
    rst_n          = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners: identity, extremes, zero weight and coefficient,
    // singular matrices, saturation, negative determinant.
    pending_items.push_back(diag_item(32'h1_0000, 32'h1_0000, 32'h1_0000, 16'hffff,
                                      32'h1_0000));
    pending_items.push_back(diag_item(32'h1_0000, 32'h1_0000, 32'h1_0000, 16'h0,
                                      32'h1_0000));
    pending_items.push_back(diag_item(32'h1_0000, 32'h1_0000, 32'h1_0000, 16'hffff, 32'h0));
    pending_items.push_back(diag_item(32'h1_0000, 32'h0, 32'h1_0000, 16'hffff, 32'h1_0000));
    pending_items.push_back(diag_item(32'h0, 32'h0, 32'h0, 16'h0, 32'h0));
    pending_items.push_back(diag_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                      16'hffff, 32'h7fff_ffff));
    pending_items.push_back(diag_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      16'hffff, 32'h8000_0000));
    pending_items.push_back(diag_item(32'h1, 32'h1, 32'h1, 16'hffff, 32'h7fff_ffff));
    pending_items.push_back(diag_item(32'h1, 32'h1, 32'h1, 16'hffff, 32'h8000_0000));
    pending_items.push_back(diag_item(32'hffff_0000, 32'h1_0000, 32'h1_0000, 16'h8000,
                                      32'hfffe_0000));
    pending_items.push_back(diag_item(32'h1, 32'h1, 32'h2, 16'h1, 32'h1));
    pending_items.push_back(diag_item(32'h3, 32'h3, 32'h3, 16'h3, 32'h1));
    begin
      cqgf_pkg::in_item_t full;
      full = '1;
      pending_items.push_back(full);
      full = {{9{32'h8000_0000}}, 16'hffff, 32'h7fff_ffff};
      pending_items.push_back(full);
    end
    for (int i = 0; i < 8; i++) pending_items.push_back(rand_item());
    while (pending_items.size() != 0) @(posedge clk);

    run_phase(500, 0, 0);
    run_phase(400, 67, 0);
    run_phase(400, 0, 67);
    // Long hold-off while items keep coming, so the pipeline backs up into the input.
    hold_off_req = 1'b1;
    run_phase(250, 0, 0);
    run_phase(400, 23, 23);

    while (expected_factors.size() != 0 || in_valid) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
